[design/tudt_pkg.sv]
// Shared types and constants for the tilt up-direction tracker.
// No dependencies.
`timescale 1ns / 1ps
package tudt_pkg;

  localparam int unsigned AtanEntries = 24;

  localparam logic [2:0] CfgFilterShift = 3'd0;
  localparam logic [2:0] CfgEnterLevel  = 3'd1;
  localparam logic [2:0] CfgExitLevel   = 3'd2;

  typedef enum logic [2:0] {
    StIdle,
    StSquare,
    StSqrt,
    StDivide,
    StCordic,
    StOut
  } state_e;

  typedef struct packed {
    logic load;
    logic sqrt_start;
    logic sqrt_step;
    logic div_start;
    logic div_step;
    logic cordic_start;
    logic cordic_step;
    logic finish;
  } ctrl_t;

  typedef struct packed {
    logic sqrt_done;
    logic div_done;
    logic cordic_done;
    logic skip_dir;
  } status_t;

  function automatic logic [31:0] atan_lut(input logic [4:0] i);
    logic [31:0] r;
    case (i)
      5'd0:  r = 32'h20000000;
      5'd1:  r = 32'h12E4051E;
      5'd2:  r = 32'h09FB385B;
      5'd3:  r = 32'h051111D4;
      5'd4:  r = 32'h028B0D43;
      5'd5:  r = 32'h0145D7E1;
      5'd6:  r = 32'h00A2F61E;
      5'd7:  r = 32'h00517C55;
      5'd8:  r = 32'h0028BE53;
      5'd9:  r = 32'h00145F2F;
      5'd10: r = 32'h000A2F98;
      5'd11: r = 32'h000517CC;
      5'd12: r = 32'h00028BE6;
      5'd13: r = 32'h000145F3;
      5'd14: r = 32'h0000A2FA;
      5'd15: r = 32'h0000517D;
      5'd16: r = 32'h000028BE;
      5'd17: r = 32'h0000145F;
      5'd18: r = 32'h00000A30;
      5'd19: r = 32'h00000518;
      5'd20: r = 32'h0000028C;
      5'd21: r = 32'h00000146;
      5'd22: r = 32'h000000A3;
      5'd23: r = 32'h00000051;
      default: r = 32'h0;
    endcase
    return r;
  endfunction

endpackage

[design/tudt_if.sv]
// Valid/ready channel interfaces for the tracker.
// Depends on nothing.
`timescale 1ns / 1ps
interface tudt_in_if #(parameter int SAMPLE_BITS = 16);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] accel_x;
  logic signed [SAMPLE_BITS-1:0] accel_y;
  modport source (output valid, accel_x, accel_y, input ready);
  modport sink   (input valid, accel_x, accel_y, output ready);
endinterface

interface tudt_out_if;
  logic               valid;
  logic               ready;
  logic               is_flat;
  logic signed [15:0] up_x;
  logic signed [15:0] up_y;
  logic        [15:0] angle;
  logic        [15:0] magnitude;
  modport source (output valid, is_flat, up_x, up_y, angle, magnitude, input ready);
  modport sink   (input valid, is_flat, up_x, up_y, angle, magnitude, output ready);
endinterface

[design/tudt_ctrl.sv]
// Sequencer for the tracker: steps square, root, divide and CORDIC phases.
// Depends on tudt_pkg.
`timescale 1ns / 1ps
module tudt_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  input  tudt_pkg::status_t  status_i,
  output tudt_pkg::ctrl_t    ctrl_o
);

  tudt_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= tudt_pkg::StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    ctrl_o      = '0;
    in_ready_o  = 1'b0;
    out_valid_o = 1'b0;
    case (state_q)
      tudt_pkg::StIdle: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          ctrl_o.load = 1'b1;
          state_d = tudt_pkg::StSquare;
        end
      end
      tudt_pkg::StSquare: begin
        ctrl_o.sqrt_start = 1'b1;
        state_d = tudt_pkg::StSqrt;
      end
      tudt_pkg::StSqrt: begin
        if (status_i.sqrt_done) begin
          if (status_i.skip_dir) begin
            ctrl_o.finish = 1'b1;
            state_d = tudt_pkg::StOut;
          end else begin
            ctrl_o.div_start = 1'b1;
            ctrl_o.cordic_start = 1'b1;
            state_d = tudt_pkg::StDivide;
          end
        end else begin
          ctrl_o.sqrt_step = 1'b1;
        end
      end
      tudt_pkg::StDivide: begin
        ctrl_o.cordic_step = !status_i.cordic_done;
        if (status_i.div_done) begin
          state_d = tudt_pkg::StCordic;
        end else begin
          ctrl_o.div_step = 1'b1;
        end
      end
      tudt_pkg::StCordic: begin
        if (status_i.cordic_done) begin
          ctrl_o.finish = 1'b1;
          state_d = tudt_pkg::StOut;
        end else begin
          ctrl_o.cordic_step = 1'b1;
        end
      end
      tudt_pkg::StOut: begin
        out_valid_o = 1'b1;
        if (out_ready_i) begin
          state_d = tudt_pkg::StIdle;
        end
      end
      default: begin
        state_d = tudt_pkg::StIdle;
      end
    endcase
  end

endmodule

[design/tudt_dp.sv]
// Datapath for the tracker: filter, square sum, bit-serial root and divide,
// CORDIC. Depends on tudt_pkg.
`timescale 1ns / 1ps
module tudt_dp #(
  parameter int SAMPLE_BITS         = 16,
  parameter int EXTRA_FRACTION_BITS = 8,
  parameter int CORDIC_STEPS        = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [2:0]                    cfg_idx_i,
  input  logic [14:0]                   cfg_data_i,
  input  logic signed [SAMPLE_BITS-1:0] accel_x_i,
  input  logic signed [SAMPLE_BITS-1:0] accel_y_i,
  input  tudt_pkg::ctrl_t               ctrl_i,
  output tudt_pkg::status_t             status_o,
  output logic                          is_flat_o,
  output logic signed [15:0]            up_x_o,
  output logic signed [15:0]            up_y_o,
  output logic [15:0]                   angle_o,
  output logic [15:0]                   magnitude_o
);

  localparam int SW = SAMPLE_BITS + EXTRA_FRACTION_BITS;
  localparam int RW = SW + 1;
  localparam int QW = 2 * RW;
  localparam int SQ_ITERS = RW;
  localparam int SQ_CW = $clog2(SQ_ITERS + 1);
  localparam int ST = (CORDIC_STEPS > tudt_pkg::AtanEntries) ?
                      tudt_pkg::AtanEntries : CORDIC_STEPS;
  localparam int CW = SW + 19;
  localparam int DN = SW + 14;
  localparam int DIV_ITERS = SW + 15;
  localparam int DIV_CW = $clog2(DIV_ITERS + 1);
  localparam int LW = 15 + EXTRA_FRACTION_BITS;

  logic [2:0]  shift_q;
  logic [14:0] enter_q, exit_q;
  logic signed [SW-1:0] sx_q, sy_q;
  logic flat_q;

  logic signed [SW:0] tx, ty, dx, dy, stepx, stepy;
  logic signed [SW-1:0] sx_d, sy_d;
  assign tx    = {accel_x_i[SAMPLE_BITS-1], accel_x_i, {EXTRA_FRACTION_BITS{1'b0}}};
  assign ty    = {accel_y_i[SAMPLE_BITS-1], accel_y_i, {EXTRA_FRACTION_BITS{1'b0}}};
  assign dx    = tx - {sx_q[SW-1], sx_q};
  assign dy    = ty - {sy_q[SW-1], sy_q};
  assign stepx = dx >>> shift_q;
  assign stepy = dy >>> shift_q;
  assign sx_d  = SW'({sx_q[SW-1], sx_q} + stepx);
  assign sy_d  = SW'({sy_q[SW-1], sy_q} + stepy);

  logic [SW-1:0] ax, ay;
  assign ax = sx_q[SW-1] ? SW'(-sx_q) : sx_q;
  assign ay = sy_q[SW-1] ? SW'(-sy_q) : sy_q;

  logic [2*SW-1:0] sqx, sqy;
  assign sqx = ax * ax;
  assign sqy = ay * ay;

  logic [LW-1:0] ent_l, ext_l;
  logic [2*LW-1:0] ent_sq, ext_sq;
  assign ent_l  = {enter_q, {EXTRA_FRACTION_BITS{1'b0}}};
  assign ext_l  = {exit_q,  {EXTRA_FRACTION_BITS{1'b0}}};
  assign ent_sq = ent_l * ent_l;
  assign ext_sq = ext_l * ext_l;

  // Digit-by-digit root: bring down two bits of the sum per step.
  logic [QW-1:0] sum_q, src_q;
  logic [RW-1:0] root_q;
  logic [SQ_CW-1:0] sq_cnt_q;
  logic [2*LW-1:0] enter_sq_q, exit_sq_q;
  logic [QW+1:0] sq_acc_q;
  logic [QW+1:0] sq_next;
  logic [RW+1:0] sq_sub;
  assign sq_next = {sq_acc_q[QW-1:0], src_q[QW-1:QW-2]};
  assign sq_sub  = {root_q, 2'b01};

  logic [QW-1:0] enter_cmp, exit_cmp;
  assign enter_cmp = QW'(enter_sq_q);
  assign exit_cmp  = QW'(exit_sq_q);

  logic next_flat;
  logic dir_flat;
  assign next_flat = flat_q ? !(sum_q > exit_cmp) : (sum_q < enter_cmp);
  assign dir_flat  = next_flat || (sum_q == '0);

  logic [RW-1:0] half_mag;
  assign half_mag = root_q >> 1;

  logic [DN:0] num_q, num_x, num_y;
  logic [RW+1:0] drem_q, drem_sh;
  logic [DN:0] quo_q, quo_full;
  logic [DIV_CW-1:0] div_cnt_q;
  logic div_y_q, div_fin_q, div_last, q_bit;
  logic [14:0] q_clamp;
  logic signed [15:0] ux_q, uy_q;
  assign num_x    = (DN+1)'({ax, 14'd0}) + (DN+1)'(half_mag);
  assign num_y    = (DN+1)'({ay, 14'd0}) + (DN+1)'(half_mag);
  assign drem_sh  = {drem_q[RW:0], num_q[DN]};
  assign q_bit    = (drem_sh >= {2'b00, root_q});
  assign quo_full = {quo_q[DN-1:0], q_bit};
  assign q_clamp  = (quo_full > (DN+1)'(16384)) ? 15'd16384 : quo_full[14:0];
  assign div_last = ctrl_i.div_step && (div_cnt_q == DIV_CW'(DIV_ITERS - 1));

  logic signed [CW-1:0] psx, psy;
  logic signed [CW-1:0] ca_q, cb_q;
  logic [31:0] z_q;
  logic [4:0] ci_q;
  logic signed [CW-1:0] ca_sh, cb_sh;
  assign psx   = CW'($signed({sx_q, 16'd0}));
  assign psy   = CW'($signed({sy_q, 16'd0}));
  assign ca_sh = ca_q >>> ci_q;
  assign cb_sh = cb_q >>> ci_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      shift_q <= 3'd2;
      enter_q <= 15'd737;
      exit_q  <= 15'd1024;
      sx_q    <= '0;
      sy_q    <= '0;
      flat_q  <= 1'b1;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          tudt_pkg::CfgFilterShift: shift_q <= cfg_data_i[2:0];
          tudt_pkg::CfgEnterLevel:  enter_q <= cfg_data_i;
          tudt_pkg::CfgExitLevel:   exit_q  <= cfg_data_i;
          default: ;
        endcase
      end
      if (ctrl_i.load) begin
        sx_q <= sx_d;
        sy_q <= sy_d;
      end
      if (ctrl_i.finish) begin
        flat_q <= next_flat;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.sqrt_start) begin
      sum_q      <= QW'(sqx) + QW'(sqy);
      src_q      <= QW'(sqx) + QW'(sqy);
      enter_sq_q <= ent_sq;
      exit_sq_q  <= ext_sq;
      root_q     <= '0;
      sq_acc_q   <= '0;
      sq_cnt_q   <= '0;
    end else if (ctrl_i.sqrt_step) begin
      src_q    <= {src_q[QW-3:0], 2'b00};
      sq_cnt_q <= sq_cnt_q + 1'b1;
      if (sq_next >= {{(QW-RW){1'b0}}, sq_sub}) begin
        sq_acc_q <= sq_next - {{(QW-RW){1'b0}}, sq_sub};
        root_q   <= {root_q[RW-2:0], 1'b1};
      end else begin
        sq_acc_q <= sq_next;
        root_q   <= {root_q[RW-2:0], 1'b0};
      end
    end
    if (ctrl_i.div_start) begin
      num_q     <= num_x;
      drem_q    <= '0;
      quo_q     <= '0;
      div_cnt_q <= '0;
      div_y_q   <= 1'b0;
      div_fin_q <= 1'b0;
    end else if (div_last) begin
      num_q     <= num_y;
      drem_q    <= '0;
      quo_q     <= '0;
      div_cnt_q <= '0;
      div_y_q   <= 1'b1;
      if (div_y_q) begin
        uy_q      <= sy_q[SW-1] ? -$signed({1'b0, q_clamp}) : $signed({1'b0, q_clamp});
        div_fin_q <= 1'b1;
      end else begin
        ux_q <= sx_q[SW-1] ? -$signed({1'b0, q_clamp}) : $signed({1'b0, q_clamp});
      end
    end else if (ctrl_i.div_step) begin
      num_q     <= {num_q[DN-1:0], 1'b0};
      quo_q     <= quo_full;
      drem_q    <= q_bit ? drem_sh - {2'b00, root_q} : drem_sh;
      div_cnt_q <= div_cnt_q + 1'b1;
    end
    if (ctrl_i.cordic_start) begin
      ca_q <= (sy_q > 0) ? psy : -psy;
      cb_q <= (sy_q > 0) ? -psx : psx;
      z_q  <= (sy_q > 0) ? 32'h80000000 : 32'h0;
      ci_q <= '0;
    end else if (ctrl_i.cordic_step) begin
      ci_q <= ci_q + 1'b1;
      if (!cb_q[CW-1]) begin
        ca_q <= ca_q + cb_sh;
        cb_q <= cb_q - ca_sh;
        z_q  <= z_q + tudt_pkg::atan_lut(ci_q);
      end else begin
        ca_q <= ca_q - cb_sh;
        cb_q <= cb_q + ca_sh;
        z_q  <= z_q - tudt_pkg::atan_lut(ci_q);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.finish) begin
      is_flat_o   <= dir_flat;
      up_x_o      <= dir_flat ? 16'sd0 : ux_q;
      up_y_o      <= dir_flat ? 16'sd0 : uy_q;
      angle_o     <= dir_flat ? 16'd0 : 16'((z_q + 32'h8000) >> 16);
      magnitude_o <= ((root_q >> EXTRA_FRACTION_BITS) > RW'(16'hFFFF)) ? 16'hFFFF :
                     16'(root_q >> EXTRA_FRACTION_BITS);
    end
  end

  assign status_o.sqrt_done   = (sq_cnt_q == SQ_CW'(SQ_ITERS)) && !ctrl_i.sqrt_start;
  assign status_o.skip_dir    = dir_flat;
  assign status_o.div_done    = div_fin_q;
  assign status_o.cordic_done = (ci_q == 5'(ST));

endmodule

[design/tilt_up_direction_tracker_core.sv]
// Sequence: square, root, then two divides (x, then y) with the CORDIC overlapped,
// then finish; when flat or the square sum is zero, the divides and CORDIC are skipped.
// A new input transaction is taken only after the previous result is accepted.
// Reset: asynchronous active low; smoothing state zero, flat flag set,
// registers to shift 2, enter 737, exit 1024.
`timescale 1ns / 1ps
module tilt_up_direction_tracker_core #(
  parameter int SAMPLE_BITS         = 16,
  parameter int EXTRA_FRACTION_BITS = 8,
  parameter int CORDIC_STEPS        = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [14:0] cfg_data_i,
  tudt_in_if.sink     in_if,
  tudt_out_if.source  out_if
);

  tudt_pkg::ctrl_t   ctrl;
  tudt_pkg::status_t status;

  tudt_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_if.valid),
    .in_ready_o  (in_if.ready),
    .out_valid_o (out_if.valid),
    .out_ready_i (out_if.ready),
    .status_i    (status),
    .ctrl_o      (ctrl)
  );

  tudt_dp #(
    .SAMPLE_BITS         (SAMPLE_BITS),
    .EXTRA_FRACTION_BITS (EXTRA_FRACTION_BITS),
    .CORDIC_STEPS        (CORDIC_STEPS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .accel_x_i   (in_if.accel_x),
    .accel_y_i   (in_if.accel_y),
    .ctrl_i      (ctrl),
    .status_o    (status),
    .is_flat_o   (out_if.is_flat),
    .up_x_o      (out_if.up_x),
    .up_y_o      (out_if.up_y),
    .angle_o     (out_if.angle),
    .magnitude_o (out_if.magnitude)
  );

endmodule
